/* design/crt_pkg.sv */
// Shared types and constants for the retransmission table.
`timescale 1ns / 1ps

package crt_pkg;

    // Item modes carried on the request channel.
    typedef enum logic [1:0] {
        MODE_TICK     = 2'd0,
        MODE_REGISTER = 2'd1,
        MODE_INBOUND  = 2'd2,
        MODE_CLEAR    = 2'd3
    } mode_t;

    // Result kinds carried on the response channel.
    typedef enum logic [2:0] {
        KIND_RETRANSMIT  = 3'd0,
        KIND_GAVE_UP     = 3'd1,
        KIND_REGISTERED  = 3'd2,
        KIND_TABLE_FULL  = 3'd3,
        KIND_ACK_MATCHED = 3'd4,
        KIND_NO_MATCH    = 3'd5,
        KIND_TICK_DONE   = 3'd6,
        KIND_CLEARED     = 3'd7
    } kind_t;

    // Control states of the table sequencer.
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_WALK  = 2'd1,
        ST_FINAL = 2'd2
    } state_t;

    // Configuration register indexes.
    localparam logic CFG_INITIAL_TIMEOUT = 1'b0;
    localparam logic CFG_MAX_RETRANSMIT  = 1'b1;

    localparam logic [15:0] RESET_TIMEOUT     = 16'd2000;
    localparam logic [3:0]  RESET_MAX_RETX    = 4'd4;
    localparam logic [7:0]  RESPONSE_CODE_MIN = 8'h40;

    // One stored table entry.
    typedef struct packed {
        logic [15:0] msg_id;
        logic [7:0]  frame;
        logic [3:0]  retries;
        logic [31:0] timeout;
        logic [31:0] due;
    } entry_t;

    // One result item on its way to the response register.
    typedef struct packed {
        kind_t       kind;
        logic [15:0] mid;
        logic [7:0]  frame;
        logic [3:0]  retries;
        logic        last;
    } result_t;

endpackage

/* design/crt_mem.sv */
// Table memory with one write port and one registered read port.
`timescale 1ns / 1ps

module crt_mem
    import crt_pkg::*;
#(
    parameter int DEPTH = 8
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  entry_t                   wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output entry_t                   rd_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/crt_out_buf.sv */
// Response register that decouples the sequencer from the response channel.
`timescale 1ns / 1ps

module crt_out_buf
    import crt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  result_t     push_data,
    output logic        can_push,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic [2:0]  kind,
    output logic [15:0] out_mid,
    output logic [7:0]  out_frame_ref,
    output logic [3:0]  retry_count,
    output logic        last
);

    logic    valid_reg;
    result_t data_reg;

    // The slot is free when empty or when its request leaves this cycle.
    assign can_push = !valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (push)
        begin
            valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg <= push_data;
        end
    end

    assign rsp_valid     = valid_reg;
    assign kind          = data_reg.kind;
    assign out_mid       = data_reg.mid;
    assign out_frame_ref = data_reg.frame;
    assign retry_count   = data_reg.retries;
    assign last          = data_reg.last;

endmodule

/* design/con_retransmit_table.sv */
// Top level of the confirmable-message retransmission table.
`timescale 1ns / 1ps

// The table keeps up to TABLE_DEPTH outstanding confirmable messages in
// insertion order in a single memory with one read and one write port.
// Register and clear requests go from idle straight to the final state. A
// tick or an inbound request walks the stored entries one per cycle while
// the response register is free, reading entry r while writing the surviving
// entries back compacted (an inbound request that is not a response skips
// the walk, as does any request on an empty table). Each result waits for
// the response register to be free, so a slow response side stalls a tick.
// A new request is taken once the previous one has placed its last result
// in the response register; configuration is always ready.
module con_retransmit_table
    import crt_pkg::*;
#(
    parameter int TABLE_DEPTH = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [1:0]  mode,
    input  logic [31:0] now_ms,
    input  logic [15:0] mid,
    input  logic [7:0]  frame_ref,
    input  logic        msg_is_ack,
    input  logic [7:0]  msg_code,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic [2:0]  kind,
    output logic [15:0] out_mid,
    output logic [7:0]  out_frame_ref,
    output logic [3:0]  retry_count,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

    // Configuration registers.
    logic [15:0] init_timeout_reg;
    logic [3:0]  max_retx_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_timeout_reg <= RESET_TIMEOUT;
            max_retx_reg     <= RESET_MAX_RETX;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_INITIAL_TIMEOUT: init_timeout_reg <= cfg_data;
                CFG_MAX_RETRANSMIT:  max_retx_reg     <= cfg_data[3:0];
                default:             ;
            endcase
        end
    end

    // Sequencer state and the request being served.
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]   wr_idx_reg, wr_idx_next;
    logic               found_reg, found_next;
    entry_t             found_ent_reg, found_ent_next;
    mode_t              mode_reg, mode_next;
    logic [31:0]        now_reg, now_next;
    logic [15:0]        mid_reg, mid_next;
    logic [7:0]         frame_reg, frame_next;

    // Memory and response register connections.
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    entry_t             mem_wdata;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_raddr;
    entry_t             mem_rdata;
    logic               out_push;
    result_t            out_data;
    logic               out_free;

    crt_mem #(
        .DEPTH (TABLE_DEPTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    crt_out_buf u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (out_push),
        .push_data     (out_data),
        .can_push      (out_free),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .kind          (kind),
        .out_mid       (out_mid),
        .out_frame_ref (out_frame_ref),
        .retry_count   (retry_count),
        .last          (last)
    );

    // Per-entry decisions during a walk.
    logic        is_tick;
    logic        due_hit;
    logic        give_up;
    logic        id_hit;
    logic        drop;
    logic        need_out;
    logic [31:0] dbl_timeout;
    entry_t      upd_ent;
    logic [CNT_W-1:0] rd_idx_inc;
    logic        is_response;

    assign is_tick     = (mode_reg == MODE_TICK);
    assign due_hit     = (now_reg >= mem_rdata.due);
    assign give_up     = due_hit && (mem_rdata.retries >= max_retx_reg);
    assign id_hit      = !found_reg && (mem_rdata.msg_id == mid_reg);
    assign drop        = is_tick ? give_up : id_hit;
    assign need_out    = is_tick && due_hit;
    assign dbl_timeout = {mem_rdata.timeout[30:0], 1'b0};
    assign rd_idx_inc  = rd_idx_reg + CNT_W'(1);
    assign is_response = msg_is_ack || (msg_code >= RESPONSE_CODE_MIN);

    // A due entry that stays is retransmitted with doubled timeout.
    always_comb
    begin
        upd_ent = mem_rdata;
        if (is_tick && due_hit)
        begin
            upd_ent.retries = mem_rdata.retries + 4'd1;
            upd_ent.timeout = dbl_timeout;
            upd_ent.due     = now_reg + dbl_timeout;
        end
    end

    // Next state and outputs of the sequencer.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        wr_idx_next    = wr_idx_reg;
        found_next     = found_reg;
        found_ent_next = found_ent_reg;
        mode_next      = mode_reg;
        now_next       = now_reg;
        mid_next       = mid_reg;
        frame_next     = frame_reg;
        item_ready     = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = wr_idx_reg[IDX_W-1:0];
        mem_wdata      = upd_ent;
        mem_re         = 1'b0;
        mem_raddr      = '0;
        out_push       = 1'b0;
        out_data       = '{kind: KIND_TICK_DONE, mid: '0, frame: '0, retries: '0,
                           last: 1'b1};

        case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    mode_next   = mode_t'(mode);
                    now_next    = now_ms;
                    mid_next    = mid;
                    frame_next  = frame_ref;
                    rd_idx_next = '0;
                    wr_idx_next = '0;
                    found_next  = 1'b0;
                    state_next  = ST_FINAL;
                    // Start a walk from the first entry when there is work.
                    if (count_reg != '0 && (mode_t'(mode) == MODE_TICK ||
                        (mode_t'(mode) == MODE_INBOUND && is_response)))
                    begin
                        mem_re     = 1'b1;
                        state_next = ST_WALK;
                    end
                end
            end

            ST_WALK:
            begin
                if (!(need_out && !out_free))
                begin
                    // Survivors are written back compacted.
                    if (!drop)
                    begin
                        mem_we      = 1'b1;
                        wr_idx_next = wr_idx_reg + CNT_W'(1);
                    end
                    if (!is_tick && id_hit)
                    begin
                        found_next     = 1'b1;
                        found_ent_next = mem_rdata;
                    end
                    // A dropped entry reports the retries it had.
                    if (need_out)
                    begin
                        out_push         = 1'b1;
                        out_data.kind    = give_up ? KIND_GAVE_UP : KIND_RETRANSMIT;
                        out_data.mid     = mem_rdata.msg_id;
                        out_data.frame   = mem_rdata.frame;
                        out_data.retries = give_up ? mem_rdata.retries : upd_ent.retries;
                        out_data.last    = 1'b0;
                    end
                    rd_idx_next = rd_idx_inc;
                    if (rd_idx_inc < count_reg)
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = rd_idx_inc[IDX_W-1:0];
                    end
                    else
                    begin
                        count_next = drop ? wr_idx_reg : wr_idx_reg + CNT_W'(1);
                        state_next = ST_FINAL;
                    end
                end
            end

            ST_FINAL:
            begin
                mem_waddr = count_reg[IDX_W-1:0];
                mem_wdata = '{msg_id: mid_reg, frame: frame_reg, retries: '0,
                              timeout: {16'd0, init_timeout_reg},
                              due: now_reg + {16'd0, init_timeout_reg}};
                case (mode_reg)
                    MODE_TICK:
                    begin
                        out_data.kind = KIND_TICK_DONE;
                    end
                    MODE_REGISTER:
                    begin
                        out_data.mid   = mid_reg;
                        out_data.frame = frame_reg;
                        out_data.kind  = (count_reg >= FULL_COUNT) ? KIND_TABLE_FULL
                                                                   : KIND_REGISTERED;
                    end
                    MODE_INBOUND:
                    begin
                        if (found_reg)
                        begin
                            out_data.kind    = KIND_ACK_MATCHED;
                            out_data.mid     = found_ent_reg.msg_id;
                            out_data.frame   = found_ent_reg.frame;
                            out_data.retries = found_ent_reg.retries;
                        end
                        else
                        begin
                            out_data.kind = KIND_NO_MATCH;
                            out_data.mid  = mid_reg;
                        end
                    end
                    MODE_CLEAR:
                    begin
                        out_data.kind = KIND_CLEARED;
                    end
                    default:
                    begin
                        out_data.kind = KIND_TICK_DONE;
                    end
                endcase
                // Side effects take place with the final result.
                if (out_free)
                begin
                    out_push   = 1'b1;
                    state_next = ST_IDLE;
                    if (mode_reg == MODE_REGISTER && count_reg < FULL_COUNT)
                    begin
                        mem_we     = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (mode_reg == MODE_CLEAR)
                    begin
                        count_next = '0;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            rd_idx_reg <= '0;
            wr_idx_reg <= '0;
            found_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rd_idx_reg <= rd_idx_next;
            wr_idx_reg <= wr_idx_next;
            found_reg  <= found_next;
        end
    end

    // Payload registers of the request being served.
    always_ff @(posedge clk)
    begin
        found_ent_reg <= found_ent_next;
        mode_reg      <= mode_next;
        now_reg       <= now_next;
        mid_reg       <= mid_next;
        frame_reg     <= frame_next;
    end

endmodule
